[src/atrlp_pkg.sv]
// Shared types and constants of the AT response line parser.
package atrlp_pkg;

    localparam int WIN_CHARS = 8;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [0:0] REG_EXPECT_WORD = 1'b0;
    localparam logic [0:0] REG_EXPECT_LEN  = 1'b1;

    // Text literals: lowest byte holds the last character.
    localparam logic [63:0] TXT_IPD     = 64'("+IPD,");
    localparam logic [63:0] TXT_OK      = 64'("OK");
    localparam logic [63:0] TXT_SEND_OK = 64'("SEND OK");
    localparam logic [63:0] TXT_ERROR   = 64'("ERROR");
    localparam logic [63:0] TXT_FAIL    = 64'("FAIL");
    localparam logic [63:0] TXT_CLOSED  = 64'("CLOSED");

    localparam logic [3:0] LEN_IPD     = 4'd5;
    localparam logic [3:0] LEN_OK      = 4'd2;
    localparam logic [3:0] LEN_SEND_OK = 4'd7;
    localparam logic [3:0] LEN_ERROR   = 4'd5;
    localparam logic [3:0] LEN_FAIL    = 4'd4;
    localparam logic [3:0] LEN_CLOSED  = 4'd6;

    typedef logic [WIN_CHARS-1:0][7:0] t_win;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_DATA = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        NUM_WS   = 2'd0,
        NUM_SIGN = 2'd1,
        NUM_DIG  = 2'd2,
        NUM_END  = 2'd3
    } t_num;

    typedef enum logic {
        ST_READY = 1'b0,
        ST_SCAN  = 1'b1
    } t_state;

    typedef struct packed {
        logic kw;
        logic ok;
        logic fail;
    } t_hits;

    // Character of "+IPD," at position idx.
    function automatic logic [7:0] ipd_char(input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            3'd0:    c = TXT_IPD[39:32];
            3'd1:    c = TXT_IPD[31:24];
            3'd2:    c = TXT_IPD[23:16];
            3'd3:    c = TXT_IPD[15:8];
            3'd4:    c = TXT_IPD[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[src/at_response_line_parser.sv]
// Top level of the AT response line parser: line store, sequencer and result register.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata rx_byte, tuser action
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata bytes/flags, tuser payload_valid
//  cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// Most requests are handled as they are accepted; a result is held in an output register.
// A line-feed that ends a command line scans the line store through its
// single read port; the next request waits until the scan has finished.
// Reset is synchronous, active low; the line store is not cleared.
// A full output register stalls the input side.
module at_response_line_parser
    import atrlp_pkg::*;
#(
    parameter int LINE_CHARS   = 256,
    parameter int EXPECT_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] line_ended,
                                        // [9] command_done, [10] command_failed,
                                        // [11] prompt_seen
    output logic [0:0]  m_axis_tuser,   // [0] payload_valid
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_CHARS);
    localparam logic [AW-1:0] LEN_MAX   = AW'(LINE_CHARS - 1);
    localparam logic [AW-1:0] IPD_CHARS = AW'(5);
    localparam logic [AW-1:0] COLON_MIN = AW'(6);

    logic [7:0]    r_mem [LINE_CHARS];
    logic [7:0]    r_rd_data;
    logic          r_rd_vld;

    logic [63:0]   r_kw;
    logic [3:0]    r_kw_len;
    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [AW-1:0] r_len, n_len;
    logic [15:0]   r_total, n_total;
    logic [15:0]   r_seen, n_seen;
    logic          r_done, n_done;
    logic          r_fail, n_fail;
    logic          r_pfx, n_pfx;
    t_num          r_num, n_num;
    logic [15:0]   r_val, n_val;
    logic          r_any, n_any;
    logic [AW-1:0] r_addr, n_addr;
    t_win          r_win, n_win;
    logic [3:0]    r_cnt, n_cnt;
    t_hits         r_hits, n_hits;
    logic          r_out_vld, n_out_vld;
    logic [15:0]   r_out_data, n_out_data;
    logic          r_out_user, n_out_user;

    logic          accept, issue, finish, wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    ch;
    logic          is_digit, is_ws;
    logic [19:0]   acc;
    logic [3:0]    kw_len;
    t_win          win_shift;
    logic [3:0]    cnt_inc;
    t_hits         hits_now;
    logic [AW-1:0] pos;

    assign ch       = s_axis_tdata;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign issue    = (r_state == ST_SCAN) && (r_addr != r_len);
    assign finish   = (r_state == ST_SCAN) && !issue && !r_rd_vld && !r_out_vld;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
    assign acc      = ({4'd0, r_val} << 3) + ({4'd0, r_val} << 1) + 20'(ch - CH_ZERO);
    assign kw_len   = (r_kw_len > 4'(EXPECT_CHARS)) ? 4'(EXPECT_CHARS) : r_kw_len;
    assign win_shift = {r_win[WIN_CHARS-2:0], r_rd_data};
    assign cnt_inc  = (r_cnt == 4'(WIN_CHARS)) ? r_cnt : r_cnt + 4'd1;

    assign s_axis_tready = (r_state == ST_READY) && (!r_out_vld || m_axis_tready);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    atrlp_matcher u_matcher (
        .i_win    (win_shift),
        .i_cnt    (cnt_inc),
        .i_kw     (r_kw),
        .i_kw_len (kw_len),
        .o_hits   (hits_now)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_READY: begin
                if (accept && !s_axis_tuser[0] && r_mode == MODE_LINE && ch == CH_LF &&
                    r_len != '0 && !(r_pfx && r_len >= IPD_CHARS)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    n_state = ST_READY;
                end
            end
            default: n_state = ST_READY;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_len      = r_len;
        n_total    = r_total;
        n_seen     = r_seen;
        n_done     = r_done;
        n_fail     = r_fail;
        n_pfx      = r_pfx;
        n_num      = r_num;
        n_val      = r_val;
        n_any      = r_any;
        n_addr     = r_addr;
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_hits     = r_hits;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_data = r_out_data;
        n_out_user = r_out_user;
        wr_en      = 1'b0;
        wr_addr    = r_len;
        pos        = r_len;

        if (accept) begin
            n_out_vld  = 1'b1;
            n_out_data = '0;
            n_out_user = 1'b0;
            if (s_axis_tuser[0]) begin
                n_done = 1'b0;
                n_fail = 1'b0;
            end else begin
                n_out_data[11] = (ch == CH_GT);
                case (r_mode)
                    MODE_DATA: begin
                        n_out_user       = 1'b1;
                        n_out_data[7:0]  = ch;
                        n_seen           = r_seen + 16'd1;
                        if (n_seen >= r_total) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_LINE: begin
                        if (ch == CH_LF) begin
                            n_mode = MODE_IDLE;
                            if (r_len != '0 && r_pfx && r_len >= IPD_CHARS) begin
                                if (r_any && r_val != 16'd0) begin
                                    n_mode  = MODE_DATA;
                                    n_total = r_val;
                                    n_seen  = 16'd0;
                                end
                            end else if (r_len != '0) begin
                                n_out_vld = r_out_vld && !m_axis_tready;
                                n_out_data = r_out_data;
                                n_addr    = '0;
                                n_win     = '0;
                                n_cnt     = 4'd0;
                                n_hits    = '0;
                                n_mode    = MODE_LINE;
                            end
                        end else if (ch != CH_CR) begin
                            if (r_len < LEN_MAX) begin
                                wr_en = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                            if (wr_en) begin
                                if (pos < IPD_CHARS) begin
                                    n_pfx = r_pfx && (ch == ipd_char(pos[2:0]));
                                end else begin
                                    case (r_num)
                                        NUM_WS: begin
                                            if (is_ws) begin
                                                n_num = NUM_WS;
                                            end else if (ch == CH_PLUS) begin
                                                n_num = NUM_SIGN;
                                            end else if (is_digit) begin
                                                n_num = NUM_DIG;
                                            end else begin
                                                n_num = NUM_END;
                                            end
                                        end
                                        NUM_SIGN, NUM_DIG: begin
                                            n_num = is_digit ? NUM_DIG : NUM_END;
                                        end
                                        default: n_num = NUM_END;
                                    endcase
                                    if (is_digit && r_num != NUM_END) begin
                                        n_any = 1'b1;
                                        n_val = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                                    end
                                end
                            end
                            if (ch == CH_COLON && n_len >= COLON_MIN && n_pfx &&
                                n_any && n_val != 16'd0) begin
                                n_mode  = MODE_DATA;
                                n_total = n_val;
                                n_seen  = 16'd0;
                                n_len   = '0;
                            end
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                        if (ch != CH_LF && ch != CH_CR) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            n_len   = AW'(1);
                            n_mode  = MODE_LINE;
                            n_pfx   = (ch == ipd_char(3'd0));
                            n_num   = NUM_WS;
                            n_val   = 16'd0;
                            n_any   = 1'b0;
                        end
                    end
                endcase
            end
            n_out_data[9]  = n_done;
            n_out_data[10] = n_fail;
        end

        if (issue) begin
            n_addr = r_addr + 1'b1;
        end
        if (r_rd_vld) begin
            n_win  = win_shift;
            n_cnt  = cnt_inc;
            n_hits = r_hits | hits_now;
        end
        if (finish) begin
            n_mode = MODE_IDLE;
            if (!r_done) begin
                if (r_hits.kw) begin
                    n_done = 1'b1;
                    n_fail = 1'b0;
                end else if (kw_len == 4'd0 && r_hits.ok) begin
                    n_done = 1'b1;
                    n_fail = 1'b0;
                end else if (r_hits.fail) begin
                    n_done = 1'b1;
                    n_fail = 1'b1;
                end
            end
            n_out_vld      = 1'b1;
            n_out_user     = 1'b0;
            n_out_data     = '0;
            n_out_data[8]  = 1'b1;
            n_out_data[9]  = n_done;
            n_out_data[10] = n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= ch;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr];
        end
        r_total    <= n_total;
        r_seen     <= n_seen;
        r_pfx      <= n_pfx;
        r_num      <= n_num;
        r_val      <= n_val;
        r_any      <= n_any;
        r_addr     <= n_addr;
        r_win      <= n_win;
        r_cnt      <= n_cnt;
        r_hits     <= n_hits;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_READY;
            r_mode    <= MODE_IDLE;
            r_len     <= '0;
            r_done    <= 1'b0;
            r_fail    <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_kw      <= 64'd0;
            r_kw_len  <= 4'd0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_len     <= n_len;
            r_done    <= n_done;
            r_fail    <= n_fail;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= issue;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EXPECT_WORD: r_kw     <= i_cfg_data;
                    REG_EXPECT_LEN:  r_kw_len <= i_cfg_data[3:0];
                    default:         r_kw     <= r_kw;
                endcase
            end
        end
    end

endmodule

[src/atrlp_matcher.sv]
// Window compare of the line scan against keyword, prefixes and error words.
module atrlp_matcher
    import atrlp_pkg::*;
(
    input  t_win        i_win,
    input  logic [3:0]  i_cnt,
    input  logic [63:0] i_kw,
    input  logic [3:0]  i_kw_len,
    output t_hits       o_hits
);

    function automatic logic lit_end(input t_win w, input logic [3:0] cnt,
                                     input logic [63:0] lit, input logic [3:0] n);
        logic hit;
        hit = (cnt >= n);
        for (int k = 0; k < WIN_CHARS; k++) begin
            if (4'(k) < n && w[k] != lit[8*k +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    logic       kw_hit;
    logic [3:0] idx;

    always_comb begin
        kw_hit = (i_kw_len != 4'd0) && (i_cnt >= i_kw_len);
        idx    = 4'd0;
        for (int i = 0; i < WIN_CHARS; i++) begin
            idx = i_kw_len - 4'd1 - 4'(i);
            if (4'(i) < i_kw_len && i_kw[8*i +: 8] != i_win[idx[2:0]]) begin
                kw_hit = 1'b0;
            end
        end
    end

    assign o_hits.kw   = kw_hit;
    assign o_hits.ok   = ((i_cnt == LEN_OK) && lit_end(i_win, i_cnt, TXT_OK, LEN_OK)) ||
                         ((i_cnt == LEN_SEND_OK) &&
                          lit_end(i_win, i_cnt, TXT_SEND_OK, LEN_SEND_OK));
    assign o_hits.fail = lit_end(i_win, i_cnt, TXT_ERROR, LEN_ERROR) ||
                         lit_end(i_win, i_cnt, TXT_FAIL, LEN_FAIL) ||
                         lit_end(i_win, i_cnt, TXT_CLOSED, LEN_CLOSED);

endmodule

[tb/atrlp_checker.sv]
// Checker for the AT response line parser: predicts each result and compares it.
`timescale 1ns / 1ps
module atrlp_checker
    import atrlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_fails,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic       pvalid;
        logic [7:0] pbyte;
        logic       lend;
        logic       done;
        logic       failed;
        logic       prompt;
    } t_res;

    t_res        res_q[$];
    logic [7:0]  line_chars [256];
    int          line_len;
    int unsigned pay_total;
    int unsigned pay_count;
    logic        exp_done;
    logic        cmd_failed;
    t_mode       mode;
    logic [63:0] kw_word;
    logic [3:0]  kw_len;

    function automatic logic [63:0] text_w(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic bit match_at(input logic [63:0] w, input int n, input int s);
        for (int i = 0; i < n; i++)
            if (line_chars[s + i] != w[8*i +: 8]) return 0;
        return 1;
    endfunction

    function automatic bit has_prefix(input logic [63:0] w, input int n);
        return n <= line_len && match_at(w, n, 0);
    endfunction

    function automatic bit has_text(input logic [63:0] w, input int n);
        if (n > line_len) return 0;
        for (int s = 0; s + n <= line_len; s++)
            if (match_at(w, n, s)) return 1;
        return 0;
    endfunction

    function automatic bit parse_len(output int unsigned v);
        int  p;
        bit  any;
        logic [7:0] c;
        p = 5;
        v = 0;
        any = 0;
        while (p < line_len) begin
            c = line_chars[p];
            if (c != CH_SPACE && c != CH_TAB && c != CH_VT && c != CH_FF) break;
            p++;
        end
        if (p < line_len && line_chars[p] == "-") return 0;
        if (p < line_len && line_chars[p] == CH_PLUS) p++;
        while (p < line_len && line_chars[p] >= CH_ZERO && line_chars[p] <= CH_NINE) begin
            v = v * 10 + 32'(line_chars[p] - CH_ZERO);
            if (v > 65535) v = 65535;
            any = 1;
            p++;
        end
        return any && v != 0;
    endfunction

    function automatic void check_line();
        int n;
        n = (kw_len > 8) ? 8 : int'(kw_len);
        if (!exp_done && n > 0 && has_text(kw_word, n)) begin
            exp_done = 1'b1;
            cmd_failed = 1'b0;
        end
        if (!exp_done && n == 0 &&
            (has_prefix(text_w("OK"), 2) || has_prefix(text_w("SEND OK"), 7))) begin
            exp_done = 1'b1;
            cmd_failed = 1'b0;
        end
        if (!exp_done && (has_text(text_w("ERROR"), 5) || has_text(text_w("FAIL"), 4) ||
                          has_text(text_w("CLOSED"), 6))) begin
            exp_done = 1'b1;
            cmd_failed = 1'b1;
        end
    endfunction

    function automatic t_res parse_byte(input logic act, input logic [7:0] ch);
        t_res        r;
        int unsigned plen;
        r = '0;
        if (act) begin
            exp_done = 1'b0;
            cmd_failed = 1'b0;
        end else begin
            r.prompt = (ch == CH_GT);
            case (mode)
                MODE_DATA: begin
                    r.pvalid = 1'b1;
                    r.pbyte = ch;
                    pay_count++;
                    if (pay_count >= pay_total) mode = MODE_IDLE;
                end
                MODE_LINE: begin
                    if (ch == CH_LF) begin
                        if (line_len == 0) begin
                            mode = MODE_IDLE;
                        end else if (has_prefix(text_w("+IPD,"), 5)) begin
                            if (parse_len(plen)) begin
                                pay_total = plen;
                                pay_count = 0;
                                mode = MODE_DATA;
                            end else begin
                                mode = MODE_IDLE;
                            end
                        end else begin
                            check_line();
                            r.lend = 1'b1;
                            mode = MODE_IDLE;
                        end
                    end else if (ch != CH_CR) begin
                        if (line_len < 255) begin
                            line_chars[line_len] = ch;
                            line_len++;
                        end
                        if (ch == CH_COLON && line_len >= 6 &&
                            has_prefix(text_w("+IPD,"), 5) && parse_len(plen)) begin
                            pay_total = plen;
                            pay_count = 0;
                            mode = MODE_DATA;
                            line_len = 0;
                        end
                    end
                end
                default: begin
                    mode = MODE_IDLE;
                    if (ch != CH_LF && ch != CH_CR) begin
                        line_chars[0] = ch;
                        line_len = 1;
                        mode = MODE_LINE;
                    end
                end
            endcase
        end
        r.done = exp_done;
        r.failed = cmd_failed;
        return r;
    endfunction

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] exp);
        $display("mismatch at result %0d: %s got %0h expected %0h", o_results, field, got, exp);
        o_fails++;
    endtask

    initial begin
        o_fails = 0;
        o_results = 0;
    end

    assign o_pending = res_q.size();

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            res_q.delete();
            mode = MODE_IDLE;
            line_len = 0;
            pay_total = 0;
            pay_count = 0;
            exp_done = 1'b0;
            cmd_failed = 1'b0;
            kw_word = '0;
            kw_len = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_EXPECT_WORD) kw_word = i_cfg_data;
                else kw_len = i_cfg_data[3:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                res_q.push_back(parse_byte(s_axis_tuser[0], s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (res_q.size() == 0) begin
                    $display("unexpected result %0h", m_axis_tdata);
                    o_fails++;
                end else begin
                    e = res_q.pop_front();
                    if (m_axis_tuser[0] != e.pvalid)
                        report("payload_valid", 8'(m_axis_tuser[0]), 8'(e.pvalid));
                    if (m_axis_tdata[7:0] != e.pbyte)
                        report("payload_byte", m_axis_tdata[7:0], e.pbyte);
                    if (m_axis_tdata[8] != e.lend)
                        report("line_ended", 8'(m_axis_tdata[8]), 8'(e.lend));
                    if (m_axis_tdata[9] != e.done)
                        report("command_done", 8'(m_axis_tdata[9]), 8'(e.done));
                    if (m_axis_tdata[10] != e.failed)
                        report("command_failed", 8'(m_axis_tdata[10]), 8'(e.failed));
                    if (m_axis_tdata[11] != e.prompt)
                        report("prompt_seen", 8'(m_axis_tdata[11]), 8'(e.prompt));
                    if (m_axis_tdata[15:12] != 4'h0)
                        report("tdata pad", 8'(m_axis_tdata[15:12]), 8'h00);
                end
                o_results++;
            end
        end
    end

endmodule

[tb/tb.sv]
// Testbench top for the AT response line parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
    import atrlp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SCAN_WAIT   = 300;
    localparam logic ACT_RX    = 1'b0;
    localparam logic ACT_ARM   = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    int          fails;
    int          pending;
    int          results;
    int          sent;
    int          cycles;
    bit          idle_on;
    bit          hold_req;
    logic [63:0] cur_word;
    int          cur_len;

    at_response_line_parser uut (.*);

    atrlp_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fails(fails), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] text_w(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
        return w;
    endfunction

    task automatic put(input logic act, input logic [7:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tuser <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) put(ACT_RX, s[i]);
    endtask

    task automatic end_line();
        if ($urandom_range(0, 1)) put(ACT_RX, CH_CR);
        put(ACT_RX, CH_LF);
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) put(ACT_RX, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_plain(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_LF || c == CH_COLON) c = "x";
            put(ACT_RX, c);
        end
    endtask

    task automatic send_payload(input int n);
        send_noise(n);
    endtask

    task automatic set_cfg(input logic [63:0] word, input logic [3:0] len);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SCAN_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_EXPECT_WORD;
        i_cfg_data <= word;
        @(posedge i_clk);
        i_cfg_idx <= REG_EXPECT_LEN;
        i_cfg_data <= {60'h0, len};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_word = word;
        cur_len = (len > 8) ? 8 : int'(len);
    endtask

    task automatic send_ipd_number();
        case ($urandom_range(0, 3))
            0: send_text(" ");
            1: send_text("\t+");
            2: put(ACT_RX, CH_VT);
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) put(ACT_RX, CH_PLUS);
    endtask

    task automatic rand_line();
        int n;
        case ($urandom_range(0, 12))
            0: begin send_text("OK"); send_plain($urandom_range(0, 4)); end_line(); end
            1: begin send_text("SEND OK"); end_line(); end
            2: begin send_plain($urandom_range(0, 5)); send_text("ERROR"); end_line(); end
            3: begin send_plain($urandom_range(0, 5)); send_text("FAIL"); end_line(); end
            4: begin send_text("CLOSED"); send_plain($urandom_range(0, 3)); end_line(); end
            5: begin
                send_plain($urandom_range(0, 4));
                for (int i = 0; i < cur_len; i++) put(ACT_RX, cur_word[8*i +: 8]);
                send_plain($urandom_range(0, 4));
                end_line();
            end
            6, 7: begin
                n = $urandom_range(1, 16);
                send_text("+IPD,");
                send_ipd_number();
                send_text($sformatf("%0d", n));
                if ($urandom_range(0, 1)) send_text(",1.2.3.4");
                put(ACT_RX, CH_COLON);
                send_payload(n);
            end
            8: begin
                n = $urandom_range(1, 12);
                send_text($sformatf("+IPD,%0d", n));
                end_line();
                send_payload(n);
            end
            9: begin
                case ($urandom_range(0, 3))
                    0: send_text("+IPD,-3:");
                    1: send_text("+IPD,0:");
                    2: send_text("+IPD, x:");
                    default: send_text("+IPD,");
                endcase
                end_line();
            end
            10: put(ACT_ARM, 8'($urandom_range(0, 255)));
            11: begin send_noise($urandom_range(1, 12)); end_line(); end
            default: begin put(ACT_RX, CH_GT); if ($urandom_range(0, 1)) put(ACT_RX, CH_CR); end
        endcase
    endtask

    task automatic random_phase(input int items);
        int stop;
        stop = sent + items;
        while (sent < stop) begin
            if ($urandom_range(0, 3) == 0) put(ACT_ARM, 8'($urandom_range(0, 255)));
            rand_line();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_EXPECT_WORD;
        i_cfg_data = 64'h0;
        idle_on = 0;
        hold_req = 0;
        sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_cfg(64'h0, 4'd0);
        put(ACT_RX, CH_CR);
        put(ACT_RX, CH_LF);
        put(ACT_ARM, 8'hFF);
        send_text("OK\r\n");
        put(ACT_ARM, 8'h00);
        send_text("SEND OK\n");
        put(ACT_ARM, 8'h5A);
        send_text("x");
        put(ACT_RX, 8'h00);
        send_text("ERROR\n");
        put(ACT_RX, CH_GT);
        put(ACT_RX, 8'h00);
        end_line();
        send_text("+IPD,\t+2:");
        send_text(">\n");
        send_text("+IPD,-1\n+IPD,0\n+IPD,\n");
        send_text("+IPD,3");
        send_plain(260);
        put(ACT_RX, CH_COLON);
        send_text("a>b");
        send_text("OK");
        send_plain(256);
        end_line();

        idle_on = 1;
        random_phase(50);
        set_cfg(text_w("CONNECT"), 4'd7);
        random_phase(50);
        hold_req = 1;
        random_phase(30);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        random_phase(40);
        set_cfg(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        random_phase(40);
        set_cfg(64'h0, 4'd2);
        random_phase(30);
        set_cfg(text_w("WIFI GOT"), 4'd8);
        random_phase(30);
        set_cfg(text_w("O"), 4'd1);
        idle_on = 0;
        random_phase(30);
        put(ACT_RX, CH_LF);
        send_text("+IPD,65536:");
        send_payload(20);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (SCAN_WAIT) @(posedge i_clk);
        $display("run covered %0d requests and %0d results over %0d cycles", sent, results,
                 cycles);
        $display("lines, IPD payloads, arm requests, prompts and six keyword settings");
        if (fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
